// ===== rtl/lsa_pkg.sv =====
// Shared types and constants for the LRU slot allocator.
// Pool size, link and slot widths, and request codes.
// No dependencies.
package lsa_pkg;

    localparam int SLOTS  = 1024;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int LINK_W = $clog2(SLOTS + 1);
    localparam int CFG_W  = 11;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(SLOTS);
    localparam logic [LINK_W-1:0] HALF_POOL = LINK_W'(SLOTS / 2);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    localparam logic [CFG_W-1:0] EVICT_BATCH_RST = CFG_W'(1);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_TOUCH = 1'b1;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [LINK_W-1:0] link_t;

endpackage

// ===== rtl/lru_slot_allocator_core.sv =====
// LRU slot allocator: top level with sequencer, list registers and result register.
// Depends on lsa_pkg and lsa_ram.
//
// Steps from accept to out_valid: a touch checks the slot, unlinks it and relinks
// it at the head, or fails at the check; an allocate evicts up to the batch size from
// the tail when the pool is at least half used, then pops a free slot and links it
// at the head, or fails when nothing is left to pop. The sequencer is back in idle as
// the result is loaded; in_stall is high outside idle. Rate is set by the single write
// port of each link RAM: one eviction per cycle. Reset: asynchronous, active low; a
// clearing pass over SLOTS (1024) initialises the in-use and free-stack RAMs.
module lru_slot_allocator_core
    import lsa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration
    input  logic              cfg_wr_en,
    input  logic [CFG_W-1:0]  cfg_wr_data,
    // request channel
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              operation,
    input  logic [SLOT_W-1:0] slot_in,
    // result channel
    output logic              out_valid,
    input  logic              out_stall,
    output logic [SLOT_W-1:0] slot_out,
    output logic              error
);

    // Sequencer states
    localparam logic [3:0] ST_CLEAR    = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_CHK      = 4'd2;
    localparam logic [3:0] ST_LINK_A   = 4'd3;
    localparam logic [3:0] ST_LINK_B   = 4'd4;
    localparam logic [3:0] ST_EVICT    = 4'd5;
    localparam logic [3:0] ST_POP      = 4'd6;
    localparam logic [3:0] ST_POP_DATA = 4'd7;
    localparam logic [3:0] ST_FIN      = 4'd8;

    logic [3:0] state_reg, state_next;

    // List and pool bookkeeping
    link_t             head_reg, head_next;
    link_t             tail_reg, tail_next;
    link_t             used_reg, used_next;
    link_t             ftop_reg, ftop_next;
    logic [CFG_W-1:0]  batch_reg;
    logic [CFG_W-1:0]  left_reg, left_next;
    slot_t             clr_reg, clr_next;
    slot_t             cur_reg, cur_next;

    // Result register and held result while the output is busy
    logic              out_valid_reg, out_valid_next;
    slot_t             out_slot_reg, out_slot_next;
    logic              out_error_reg, out_error_next;
    slot_t             pend_slot_reg, pend_slot_next;
    logic              pend_error_reg, pend_error_next;

    logic              res_req;
    slot_t             res_slot;
    logic              res_err;
    logic              out_free;

    // RAM ports
    logic              nx_we, pv_we, us_we, st_we;
    slot_t             nx_waddr, pv_waddr, us_waddr, st_waddr;
    link_t             nx_wdata, pv_wdata;
    logic              us_wdata;
    slot_t             st_wdata;
    slot_t             nx_raddr, pv_raddr, us_raddr, st_raddr;
    link_t             nx_rdata, pv_rdata;
    logic              us_rdata;
    slot_t             st_rdata;

    link_t             ftop_dec;
    slot_t             pop_slot;
    logic              touch_bad;
    logic              evict_go;

    lsa_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_next_ram (
        .clk   (clk),
        .we    (nx_we),
        .waddr (nx_waddr),
        .wdata (nx_wdata),
        .raddr (nx_raddr),
        .rdata (nx_rdata)
    );

    lsa_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_prev_ram (
        .clk   (clk),
        .we    (pv_we),
        .waddr (pv_waddr),
        .wdata (pv_wdata),
        .raddr (pv_raddr),
        .rdata (pv_rdata)
    );

    lsa_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_use_ram (
        .clk   (clk),
        .we    (us_we),
        .waddr (us_waddr),
        .wdata (us_wdata),
        .raddr (us_raddr),
        .rdata (us_rdata)
    );

    lsa_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_stack_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_out  = out_slot_reg;
    assign error     = out_error_reg;

    // Room in the result register this cycle: empty, or its transaction completes now
    assign out_free  = !out_valid_reg || !out_stall;

    assign ftop_dec  = ftop_reg - LINK_W'(1);
    // A popped entry beyond the pool falls back to slot zero
    assign pop_slot  = (LINK_W'(st_rdata) < NULL_LINK) ? st_rdata : '0;
    // Touch of a slot outside the pool or of a free slot fails
    assign touch_bad = (LINK_W'(cur_reg) >= NULL_LINK) || !us_rdata;
    assign evict_go  = (left_reg != '0) && (used_reg != '0) && (tail_reg < NULL_LINK);

    // Read addresses. The touch reads are issued on the accept edge from the port;
    // the eviction walk chases the prev link straight from the RAM output.
    always_comb
    begin
        nx_raddr = slot_in;
        us_raddr = slot_in;
        st_raddr = ftop_dec[SLOT_W-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                pv_raddr = (operation == OP_TOUCH) ? slot_in : tail_reg[SLOT_W-1:0];
            end
            ST_EVICT:
            begin
                pv_raddr = pv_rdata[SLOT_W-1:0];
            end
            default:
            begin
                pv_raddr = slot_in;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        used_next       = used_reg;
        ftop_next       = ftop_reg;
        left_next       = left_reg;
        clr_next        = clr_reg;
        cur_next        = cur_reg;

        nx_we    = 1'b0;
        nx_waddr = cur_reg;
        nx_wdata = head_reg;
        pv_we    = 1'b0;
        pv_waddr = cur_reg;
        pv_wdata = NULL_LINK;
        us_we    = 1'b0;
        us_waddr = cur_reg;
        us_wdata = 1'b0;
        st_we    = 1'b0;
        st_waddr = ftop_reg[SLOT_W-1:0];
        st_wdata = tail_reg[SLOT_W-1:0];

        res_req  = 1'b0;
        res_slot = cur_reg;
        res_err  = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                // Mark every slot free and load the free stack with its own index
                us_we    = 1'b1;
                us_waddr = clr_reg;
                us_wdata = 1'b0;
                st_we    = 1'b1;
                st_waddr = clr_reg;
                st_wdata = clr_reg;
                clr_next = clr_reg + SLOT_W'(1);
                if (clr_reg == LAST_SLOT)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cur_next = slot_in;
                    if (operation == OP_TOUCH)
                    begin
                        state_next = ST_CHK;
                    end
                    else if (used_reg >= HALF_POOL)
                    begin
                        left_next  = batch_reg;
                        state_next = ST_EVICT;
                    end
                    else
                    begin
                        // Stack top was read on the accept edge
                        state_next = ST_POP_DATA;
                    end
                end
            end

            ST_CHK:
            begin
                if (touch_bad)
                begin
                    res_req  = 1'b1;
                    res_slot = cur_reg;
                    res_err  = 1'b1;
                end
                else
                begin
                    // Unlink: bridge the neighbours around the touched slot
                    if (pv_rdata < NULL_LINK)
                    begin
                        nx_we    = 1'b1;
                        nx_waddr = pv_rdata[SLOT_W-1:0];
                        nx_wdata = nx_rdata;
                    end
                    else
                    begin
                        head_next = nx_rdata;
                    end
                    if (nx_rdata < NULL_LINK)
                    begin
                        pv_we    = 1'b1;
                        pv_waddr = nx_rdata[SLOT_W-1:0];
                        pv_wdata = pv_rdata;
                    end
                    else
                    begin
                        tail_next = pv_rdata;
                    end
                    state_next = ST_LINK_A;
                end
            end

            ST_LINK_A:
            begin
                nx_we    = 1'b1;
                nx_waddr = cur_reg;
                nx_wdata = head_reg;
                if (head_reg < NULL_LINK)
                begin
                    pv_we    = 1'b1;
                    pv_waddr = head_reg[SLOT_W-1:0];
                    pv_wdata = LINK_W'(cur_reg);
                end
                state_next = ST_LINK_B;
            end

            ST_LINK_B:
            begin
                pv_we     = 1'b1;
                pv_waddr  = cur_reg;
                pv_wdata  = NULL_LINK;
                head_next = LINK_W'(cur_reg);
                if (tail_reg >= NULL_LINK)
                begin
                    tail_next = LINK_W'(cur_reg);
                end
                res_req  = 1'b1;
                res_slot = cur_reg;
                res_err  = 1'b0;
            end

            ST_EVICT:
            begin
                if (evict_go)
                begin
                    // Drop the tail slot; its prev link is on the RAM output
                    if (pv_rdata < NULL_LINK)
                    begin
                        nx_we    = 1'b1;
                        nx_waddr = pv_rdata[SLOT_W-1:0];
                        nx_wdata = NULL_LINK;
                    end
                    else
                    begin
                        head_next = NULL_LINK;
                    end
                    tail_next = pv_rdata;
                    us_we     = 1'b1;
                    us_waddr  = tail_reg[SLOT_W-1:0];
                    us_wdata  = 1'b0;
                    if (ftop_reg < NULL_LINK)
                    begin
                        st_we     = 1'b1;
                        st_waddr  = ftop_reg[SLOT_W-1:0];
                        st_wdata  = tail_reg[SLOT_W-1:0];
                        ftop_next = ftop_reg + LINK_W'(1);
                    end
                    used_next = used_reg - LINK_W'(1);
                    left_next = left_reg - CFG_W'(1);
                end
                else
                begin
                    state_next = ST_POP;
                end
            end

            ST_POP:
            begin
                if (ftop_reg == '0)
                begin
                    res_req  = 1'b1;
                    res_slot = '0;
                    res_err  = 1'b1;
                end
                else
                begin
                    state_next = ST_POP_DATA;
                end
            end

            ST_POP_DATA:
            begin
                // Take the popped slot and link it ahead of the current head
                cur_next  = pop_slot;
                us_we     = 1'b1;
                us_waddr  = pop_slot;
                us_wdata  = 1'b1;
                used_next = used_reg + LINK_W'(1);
                ftop_next = ftop_dec;
                nx_we     = 1'b1;
                nx_waddr  = pop_slot;
                nx_wdata  = head_reg;
                if (head_reg < NULL_LINK)
                begin
                    pv_we    = 1'b1;
                    pv_waddr = head_reg[SLOT_W-1:0];
                    pv_wdata = LINK_W'(pop_slot);
                end
                state_next = ST_LINK_B;
            end

            ST_FIN:
            begin
                res_req  = 1'b1;
                res_slot = pend_slot_reg;
                res_err  = pend_error_reg;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Hand the result to the output register, or hold it until there is room
        if (res_req)
        begin
            if (out_free)
            begin
                state_next = ST_IDLE;
            end
            else
            begin
                state_next = ST_FIN;
            end
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_slot_next   = out_slot_reg;
        out_error_next  = out_error_reg;
        pend_slot_next  = pend_slot_reg;
        pend_error_next = pend_error_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (res_req)
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
                out_slot_next  = res_slot;
                out_error_next = res_err;
            end
            else
            begin
                pend_slot_next  = res_slot;
                pend_error_next = res_err;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            head_reg      <= NULL_LINK;
            tail_reg      <= NULL_LINK;
            used_reg      <= '0;
            ftop_reg      <= NULL_LINK;
            batch_reg     <= EVICT_BATCH_RST;
            left_reg      <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            used_reg      <= used_next;
            ftop_reg      <= ftop_next;
            left_reg      <= left_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                batch_reg <= cfg_wr_data;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        out_slot_reg   <= out_slot_next;
        out_error_reg  <= out_error_next;
        pend_slot_reg  <= pend_slot_next;
        pend_error_reg <= pend_error_next;
    end

endmodule

// ===== rtl/lsa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for every store of the allocator. No package dependency.
module lsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
